// ===== rtl/mbsp_pkg.sv =====
// shared types and constants for the midi byte stream parser
// no dependencies
package mbsp_pkg;

  localparam int unsigned MaxResults = 2;

  typedef enum logic [3:0] {
    EV_NOTE_ON    = 4'd0,
    EV_NOTE_OFF   = 4'd1,
    EV_CC         = 4'd2,
    EV_BEND       = 4'd3,
    EV_PROGRAM    = 4'd4,
    EV_SYSEX_BYTE = 4'd5,
    EV_SYSEX_END  = 4'd6,
    EV_RESET      = 4'd7,
    EV_BAD_STATUS = 4'd8,
    EV_BAD_SYSTEM = 4'd9
  } mbsp_kind_t;

  typedef enum logic [6:0] {
    PH_STATUS = 7'b0000001,
    PH_DATA1  = 7'b0000010,
    PH_DATA2  = 7'b0000100,
    PH_PROG   = 7'b0001000,
    PH_SYSEX  = 7'b0010000,
    PH_SPP1   = 7'b0100000,
    PH_SPP2   = 7'b1000000
  } mbsp_phase_t;

  // status high nibbles
  localparam logic [3:0] HiNoteOff = 4'h8;
  localparam logic [3:0] HiNoteOn  = 4'h9;
  localparam logic [3:0] HiCc      = 4'hB;
  localparam logic [3:0] HiProg    = 4'hC;
  localparam logic [3:0] HiBend    = 4'hE;
  localparam logic [3:0] HiSystem  = 4'hF;

  // system status low nibbles
  localparam logic [3:0] LoSysex    = 4'h0;
  localparam logic [3:0] LoSongPos  = 4'h2;
  localparam logic [3:0] LoClock    = 4'h8;
  localparam logic [3:0] LoStart    = 4'hA;
  localparam logic [3:0] LoContinue = 4'hB;
  localparam logic [3:0] LoStop     = 4'hC;
  localparam logic [3:0] LoReset    = 4'hF;

  localparam logic [7:0] SysexStatus = 8'hF0;
  localparam logic [7:0] SysexEnd    = 8'hF7;

  typedef struct packed {
    mbsp_kind_t  kind;
    logic [3:0]  channel;
    logic [7:0]  value_a;
    logic [15:0] value_b;
    logic [7:0]  raw_status;
    logic        last_of_run;
  } mbsp_result_t;

  typedef struct packed {
    logic [1:0]   count;
    mbsp_result_t first;
    mbsp_result_t second;
  } mbsp_push_t;

endpackage

// ===== rtl/mbsp_if.sv =====
// valid/ready channel interfaces for the byte input and the event output
// depends on nothing
interface mbsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mbsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [3:0]  channel;
  logic [7:0]  value_a;
  logic [15:0] value_b;
  logic [7:0]  raw_status;
  logic        last_of_run;

  modport source (output valid, output event_kind, output channel, output value_a,
                  output value_b, output raw_status, output last_of_run, input ready);
  modport sink (input valid, input event_kind, input channel, input value_a,
                input value_b, input raw_status, input last_of_run, output ready);
endinterface

// ===== rtl/mbsp_parse.sv =====
// parse phase machine: decodes one byte per transfer into zero to two events
// depends on mbsp_pkg
module mbsp_parse import mbsp_pkg::*; #(
  parameter int unsigned SYSEX_MAX = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output mbsp_push_t push
);

  localparam logic [8:0] SxMax = 9'(SYSEX_MAX);

  mbsp_phase_t phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [8:0]  sx_cnt_r, sx_cnt_nxt;

  logic [3:0]  hi, lo, held_hi, held_lo;
  logic [8:0]  sx_inc;
  logic [15:0] bend;

  assign hi      = rx_byte[7:4];
  assign lo      = rx_byte[3:0];
  assign held_hi = held_r[7:4];
  assign held_lo = held_r[3:0];
  assign sx_inc  = sx_cnt_r + 9'd1;
  assign bend    = {1'b0, rx_byte, 7'b0} + {8'b0, first_r};

  always_comb begin
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    first_nxt  = first_r;
    sx_cnt_nxt = sx_cnt_r;
    push       = '0;
    push.first.last_of_run  = 1'b1;
    push.second.last_of_run = 1'b1;
    case (phase_r)
      PH_DATA1: begin
        first_nxt = rx_byte;
        phase_nxt = PH_DATA2;
      end
      PH_DATA2: begin
        phase_nxt = PH_STATUS;
        push.count = 2'd1;
        push.first.channel    = held_lo;
        push.first.value_a    = first_r;
        push.first.raw_status = held_r;
        if (held_hi == HiNoteOn) begin
          push.first.kind    = EV_NOTE_ON;
          push.first.value_b = {8'b0, rx_byte};
        end else if (held_hi == HiNoteOff) begin
          push.first.kind = EV_NOTE_OFF;
        end else if (held_hi == HiCc) begin
          push.first.kind    = EV_CC;
          push.first.value_b = {8'b0, rx_byte};
        end else begin
          push.first.kind    = EV_BEND;
          push.first.value_a = '0;
          push.first.value_b = bend;
        end
      end
      PH_PROG: begin
        phase_nxt = PH_STATUS;
        push.count = 2'd1;
        push.first.kind       = EV_PROGRAM;
        push.first.channel    = held_lo;
        push.first.value_a    = rx_byte;
        push.first.raw_status = held_r;
      end
      PH_SYSEX: begin
        push.count = 2'd1;
        push.first.raw_status  = SysexStatus;
        push.second.raw_status = SysexStatus;
        if (rx_byte == SysexEnd) begin
          push.first.kind    = EV_SYSEX_END;
          push.first.value_b = {7'b0, sx_cnt_r};
          phase_nxt  = PH_STATUS;
          sx_cnt_nxt = '0;
        end else begin
          push.first.kind    = EV_SYSEX_BYTE;
          push.first.value_a = rx_byte;
          push.first.value_b = {7'b0, sx_cnt_r};
          sx_cnt_nxt = sx_inc;
          if (sx_inc >= SxMax) begin
            push.count = 2'd2;
            push.first.last_of_run = 1'b0;
            push.second.kind    = EV_SYSEX_END;
            push.second.value_b = {7'b0, sx_inc};
            phase_nxt  = PH_STATUS;
            sx_cnt_nxt = '0;
          end
        end
      end
      PH_SPP1: phase_nxt = PH_SPP2;
      PH_SPP2: phase_nxt = PH_STATUS;
      default: begin
        held_nxt  = rx_byte;
        phase_nxt = PH_STATUS;
        push.first.raw_status = rx_byte;
        if (hi inside {HiNoteOn, HiNoteOff, HiCc, HiBend}) begin
          phase_nxt = PH_DATA1;
        end else if (hi == HiProg) begin
          phase_nxt = PH_PROG;
        end else if (hi == HiSystem) begin
          if (lo == LoSongPos) begin
            phase_nxt = PH_SPP1;
          end else if (lo inside {LoClock, LoStart, LoContinue, LoStop}) begin
            phase_nxt = PH_STATUS;
          end else if (lo == LoSysex) begin
            sx_cnt_nxt = '0;
            phase_nxt  = PH_SYSEX;
          end else if (lo == LoReset) begin
            push.count = 2'd1;
            push.first.kind = EV_RESET;
          end else begin
            push.count = 2'd1;
            push.first.kind = EV_BAD_SYSTEM;
          end
        end else begin
          push.count = 2'd1;
          push.first.kind = EV_BAD_STATUS;
        end
      end
    endcase
    if (!take) begin
      push.count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_STATUS;
      held_r   <= '0;
      first_r  <= '0;
      sx_cnt_r <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
      first_r  <= first_nxt;
      sx_cnt_r <= sx_cnt_nxt;
    end
  end

endmodule

// ===== rtl/mbsp_outq.sv =====
// four-entry event queue: takes up to two events per cycle, gives one per transfer
// depends on mbsp_pkg
module mbsp_outq import mbsp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  mbsp_push_t   push,
  output logic         room,
  output logic         head_valid,
  input  logic         head_ready,
  output mbsp_result_t head
);

  mbsp_result_t mem_r [4];
  logic [1:0]   wr_r, rd_r;
  logic [2:0]   cnt_r, cnt_nxt;
  logic         pop;

  assign head_valid = cnt_r != 3'd0;
  assign pop        = head_valid && head_ready;
  assign room       = cnt_r <= 3'd2;
  assign head       = mem_r[rd_r];
  assign cnt_nxt    = cnt_r + {1'b0, push.count} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_r + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + push.count;
      rd_r  <= rd_r + {1'b0, pop};
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/midi_byte_stream_parser.sv =====
// midi byte stream parser top level: phase machine feeding an event queue
// depends on mbsp_pkg, mbsp_if, mbsp_parse, mbsp_outq
// an event is written to the queue on its byte transfer and offered from the queue head
// throughput: one byte per cycle while ready; a byte ending a full sysex gives two events
// in_if.ready is high while the event queue has room for two more events
// reset (synchronous, rst_n low) returns to expecting a status byte and empties the queue
module midi_byte_stream_parser import mbsp_pkg::*; #(
  parameter int unsigned SYSEX_MAX = 256
) (
  input logic        clk,
  input logic        rst_n,
  mbsp_in_if.sink    in_if,
  mbsp_out_if.source out_if
);

  mbsp_push_t   push;
  mbsp_result_t head;
  logic         room;
  logic         take;

  assign in_if.ready = room;
  assign take        = in_if.valid && room;

  mbsp_parse #(.SYSEX_MAX(SYSEX_MAX)) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_if.rx_byte),
    .push    (push)
  );

  mbsp_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_if.valid),
    .head_ready (out_if.ready),
    .head       (head)
  );

  assign out_if.event_kind  = head.kind;
  assign out_if.channel     = head.channel;
  assign out_if.value_a     = head.value_a;
  assign out_if.value_b     = head.value_b;
  assign out_if.raw_status  = head.raw_status;
  assign out_if.last_of_run = head.last_of_run;

endmodule

// ===== rtl/mbsp_checker.sv =====
// port-level checks for the midi byte stream parser, bound to the top level
// depends on mbsp_pkg and midi_byte_stream_parser
module mbsp_checker import mbsp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_kind,
  input logic [3:0]  out_channel,
  input logic [7:0]  out_value_a,
  input logic [15:0] out_value_b,
  input logic [7:0]  out_raw_status,
  input logic        out_last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value_b)
      && $stable(out_value_a))
    else $error("output event changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("event offered right after reset");

  a_sysex_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == EV_SYSEX_BYTE || out_kind == EV_SYSEX_END)
      |-> out_raw_status == SysexStatus && out_channel == 4'd0)
    else $error("sysex event without sysex status");

  a_reset_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == EV_RESET |-> out_raw_status == 8'hFF && out_last)
    else $error("reset event malformed");

  a_bend_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == EV_BEND |-> out_value_a == 8'd0 && out_last)
    else $error("pitch bend event malformed");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_kind       (out_if.event_kind),
  .out_channel    (out_if.channel),
  .out_value_a    (out_if.value_a),
  .out_value_b    (out_if.value_b),
  .out_raw_status (out_if.raw_status),
  .out_last       (out_if.last_of_run)
);
